/* hdl/srmq_pkg.sv */
// Shared constants, codes and types of the sparse-table range-minimum engine.
`default_nettype none

package srmq_pkg;

  // Parameter defaults
  localparam int unsigned MAX_ELEMENTS_DEF = 1024;
  localparam int unsigned LEVELS_DEF       = 11;
  localparam int unsigned VALUE_BITS_DEF   = 16;

  // Field widths on the stream ports
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned RS_W    = 10;
  localparam int unsigned RE_W    = 11;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned STAT_W  = 2;

  // Input tdata layout, lowest bit first
  localparam int unsigned IDX_LSB = 0;
  localparam int unsigned VAL_LSB = IDX_LSB + IDX_W;
  localparam int unsigned RS_LSB  = VAL_LSB + VAL_W;
  localparam int unsigned RE_LSB  = RS_LSB + RS_W;
  localparam int unsigned IN_BITS = RE_LSB + RE_W;
  localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

  // Output tdata layout, lowest bit first
  localparam int unsigned OUT_BITS   = VAL_W + POS_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BUILD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_BUILT = 2'd2;

  // Configuration registers
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned LEN_W      = 11;
  localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;
  localparam logic REG_LENGTH = 1'b0;   // register index, paddr[2]

  // Configuration seen by the engine
  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic             clr_built;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [VAL_W-1:0]  value;
  } res_t;

endpackage

`default_nettype wire

/* hdl/srmq_ram.sv */
// Generic synchronous RAM: one write port, two registered read ports.
`default_nettype none

module srmq_ram #(
  parameter int unsigned WIDTH = 26,
  parameter int unsigned DEPTH = 11264
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  input  wire logic                     re_b_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // Storage and registered reads
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_a_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

/* hdl/srmq_regs.sv */
// APB register block holding the element count.
`default_nettype none

module srmq_regs (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [srmq_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [srmq_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [srmq_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                     pready,
  output srmq_pkg::cfg_t                           cfg_o
);

  logic [srmq_pkg::LEN_W-1:0] length_q;
  logic [srmq_pkg::LEN_W-1:0] length_d;
  logic                       wr_len;

  // Write decode
  assign wr_len = psel && penable && pwrite && (paddr[2] == srmq_pkg::REG_LENGTH);

  always_comb begin
    length_d = length_q;
    if (wr_len) begin
      length_d = pwdata[srmq_pkg::LEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q <= srmq_pkg::LEN_RESET;
    end else begin
      length_q <= length_d;
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      srmq_pkg::REG_LENGTH: prdata = srmq_pkg::APB_DATA_W'(length_q);
      default:              prdata = '0;
    endcase
  end

  assign pready          = 1'b1;
  assign cfg_o.length    = length_q;
  assign cfg_o.clr_built = wr_len;

endmodule

`default_nettype wire

/* hdl/sparse_table_range_min.sv */
// Top level of the sparse-table range-minimum engine.
//
// Items arrive on the s_axis stream; each one gives exactly one result on the
// m_axis stream. The table sits in one RAM of LEVELS x 2^clog2(MAX_ELEMENTS)
// entries, addressed as {level, position}, with one write port and two
// registered read ports. A load is at most one RAM write, a query is two reads
// followed by a compare, and a rejected query or unused mode gives its
// result without touching the RAM. A build over n = min(length, MAX_ELEMENTS)
// elements writes, for each level i >= 1 with i < LEVELS and 2^i <= n,
// n - 2^i + 1 entries and lets the last write of each level land before the
// next, all paced by the single RAM write port at one entry per cycle. The
// table has no clearing pass: entries are valid once a build has written
// them, and a load or a write of the length register marks the table as
// stale. The engine takes one item at a time. A finished result moves to the
// output register; while that register still holds an unaccepted result, the
// new one waits in a hold register and no further item is accepted.
`default_nettype none

module sparse_table_range_min #(
  parameter int unsigned MAX_ELEMENTS = srmq_pkg::MAX_ELEMENTS_DEF,
  parameter int unsigned LEVELS       = srmq_pkg::LEVELS_DEF,
  parameter int unsigned VALUE_BITS   = srmq_pkg::VALUE_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // input stream
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // tdata: index[9:0], value[25:10], range_start[35:26], range_end[46:36]
  input  wire logic [srmq_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // tuser: mode[1:0]
  input  wire logic [srmq_pkg::MODE_W-1:0]         s_axis_tuser,
  // result stream
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // tdata: min_value[15:0], min_position[25:16]
  output logic      [srmq_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // tuser: status[1:0]
  output logic      [srmq_pkg::STAT_W-1:0]         m_axis_tuser,
  // configuration
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [srmq_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [srmq_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [srmq_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                     pready
);

  localparam int unsigned JW    = $clog2(MAX_ELEMENTS);
  localparam int unsigned LW    = $clog2(LEVELS);
  localparam int unsigned AW    = LW + JW;
  localparam int unsigned EW    = VALUE_BITS + JW;
  localparam int unsigned DEPTH = LEVELS << JW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BUILD,
    S_DRAIN,
    S_QUERY,
    S_HOLD
  } state_e;

  // Configuration
  srmq_pkg::cfg_t cfg;

  srmq_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input fields
  logic [srmq_pkg::IDX_W-1:0] in_index;
  logic [srmq_pkg::VAL_W-1:0] in_value;
  logic [srmq_pkg::RS_W-1:0]  in_start;
  logic [srmq_pkg::RE_W-1:0]  in_end;

  assign in_index = s_axis_tdata[srmq_pkg::IDX_LSB +: srmq_pkg::IDX_W];
  assign in_value = s_axis_tdata[srmq_pkg::VAL_LSB +: srmq_pkg::VAL_W];
  assign in_start = s_axis_tdata[srmq_pkg::RS_LSB +: srmq_pkg::RS_W];
  assign in_end   = s_axis_tdata[srmq_pkg::RE_LSB +: srmq_pkg::RE_W];

  // Registers
  state_e               state_q, state_d;
  logic                 built_q, built_d;
  logic [LW-1:0]        lvl_q, lvl_d;
  logic [JW-1:0]        j_q, j_d;
  logic                 wr_vld_q, wr_vld_d;
  logic [AW-1:0]        wr_addr_q, wr_addr_d;
  srmq_pkg::res_t       res_q, res_d;
  logic                 out_vld_q, out_vld_d;
  srmq_pkg::res_t       out_q, out_d;

  // RAM ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr_a;
  logic [AW-1:0] ram_raddr_b;
  logic [EW-1:0] ram_rdata_a;
  logic [EW-1:0] ram_rdata_b;

  srmq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_a_i    (ram_re),
    .raddr_a_i (ram_raddr_a),
    .rdata_a_o (ram_rdata_a),
    .re_b_i    (ram_re),
    .raddr_b_i (ram_raddr_b),
    .rdata_b_o (ram_rdata_b)
  );

  // Shared compare: lower value wins, ties go to the lower position
  logic [VALUE_BITS-1:0] a_val, b_val;
  logic [JW-1:0]         a_pos, b_pos;
  logic [EW-1:0]         pick;

  assign a_val = ram_rdata_a[VALUE_BITS-1:0];
  assign b_val = ram_rdata_b[VALUE_BITS-1:0];
  assign a_pos = ram_rdata_a[EW-1:VALUE_BITS];
  assign b_pos = ram_rdata_b[EW-1:VALUE_BITS];
  assign pick  = ((b_val < a_val) || ((b_val == a_val) && (b_pos < a_pos))) ?
                 ram_rdata_b : ram_rdata_a;

  // Effective element count
  logic [srmq_pkg::LEN_W-1:0] eff_len;

  always_comb begin
    eff_len = cfg.length;
    if (32'(cfg.length) > MAX_ELEMENTS) begin
      eff_len = srmq_pkg::LEN_W'(MAX_ELEMENTS);
    end
  end

  // Query level: floor(log2(end - start)), saturated at the top level
  logic [srmq_pkg::RE_W-1:0] q_span;
  logic [3:0]                q_k;
  logic [LW-1:0]             q_lvl;
  logic [srmq_pkg::RE_W-1:0] q_right;
  logic                      q_bad;

  assign q_span = in_end - srmq_pkg::RE_W'(in_start);
  assign q_bad  = (srmq_pkg::RE_W'(in_start) >= in_end) || (in_end > eff_len);

  always_comb begin
    q_k = '0;
    for (int b = 0; b < int'(srmq_pkg::RE_W); b++) begin
      if (q_span[b]) begin
        q_k = 4'(b);
      end
    end
    if (32'(q_k) > LEVELS - 1) begin
      q_lvl = LW'(LEVELS - 1);
    end else begin
      q_lvl = LW'(q_k);
    end
  end

  assign q_right = in_end - (srmq_pkg::RE_W'(1) << q_lvl);

  // Handshake
  logic accept;
  logic out_free;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;

  // Build loop bounds
  logic          blk_last;
  logic          lvl_more;
  logic [LW-1:0] lvl_prev;
  logic [JW-1:0] j_half;

  assign lvl_prev = lvl_q - LW'(1);
  assign j_half   = j_q + JW'(32'd1 << lvl_prev);
  assign blk_last = (32'(j_q) + 32'd1 + (32'd1 << lvl_q)) > 32'(eff_len);
  assign lvl_more = ((32'(lvl_q) + 32'd1) < LEVELS) &&
                    ((32'd1 << (32'(lvl_q) + 32'd1)) <= 32'(eff_len));

  // Control
  logic           fin;
  srmq_pkg::res_t fin_res;

  always_comb begin
    state_d     = state_q;
    built_d     = built_q;
    lvl_d       = lvl_q;
    j_d         = j_q;
    wr_vld_d    = 1'b0;
    wr_addr_d   = wr_addr_q;
    res_d       = res_q;
    out_vld_d   = out_vld_q;
    out_d       = out_q;
    fin         = 1'b0;
    fin_res     = '0;
    ram_we      = wr_vld_q;
    ram_waddr   = wr_addr_q;
    ram_wdata   = pick;
    ram_re      = 1'b0;
    ram_raddr_a = '0;
    ram_raddr_b = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (s_axis_tuser)
            srmq_pkg::MODE_LOAD: begin
              if (32'(in_index) < MAX_ELEMENTS) begin
                ram_we    = 1'b1;
                ram_waddr = {LW'(0), JW'(in_index)};
                ram_wdata = {JW'(in_index), VALUE_BITS'(in_value)};
              end
              built_d = 1'b0;
              fin     = 1'b1;
            end
            srmq_pkg::MODE_BUILD: begin
              if (eff_len >= srmq_pkg::LEN_W'(2)) begin
                state_d = S_BUILD;
                lvl_d   = LW'(1);
                j_d     = '0;
              end else begin
                built_d = 1'b1;
                fin     = 1'b1;
              end
            end
            srmq_pkg::MODE_QUERY: begin
              if (!built_q) begin
                fin            = 1'b1;
                fin_res.status = srmq_pkg::STAT_NOT_BUILT;
              end else if (q_bad) begin
                fin            = 1'b1;
                fin_res.status = srmq_pkg::STAT_BAD_RANGE;
              end else begin
                ram_re      = 1'b1;
                ram_raddr_a = {q_lvl, JW'(in_start)};
                ram_raddr_b = {q_lvl, JW'(q_right)};
                state_d     = S_QUERY;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      // One entry per cycle: read two halves of the level below
      S_BUILD: begin
        ram_re      = 1'b1;
        ram_raddr_a = {lvl_prev, j_q};
        ram_raddr_b = {lvl_prev, j_half};
        wr_vld_d    = 1'b1;
        wr_addr_d   = {lvl_q, j_q};
        if (blk_last) begin
          state_d = S_DRAIN;
        end else begin
          j_d = j_q + JW'(1);
        end
      end
      // Last write of the level lands before the next level reads it
      S_DRAIN: begin
        if (lvl_more) begin
          lvl_d   = lvl_q + LW'(1);
          j_d     = '0;
          state_d = S_BUILD;
        end else begin
          built_d = 1'b1;
          fin     = 1'b1;
        end
      end
      S_QUERY: begin
        fin              = 1'b1;
        fin_res.value    = srmq_pkg::VAL_W'(pick[VALUE_BITS-1:0]);
        fin_res.position = srmq_pkg::POS_W'(pick[EW-1:VALUE_BITS]);
        fin_res.status   = srmq_pkg::STAT_OK;
      end
      S_HOLD: begin
        fin     = 1'b1;
        fin_res = res_q;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Output register and result hand-off
    if (m_axis_tvalid && m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    if (fin) begin
      if (out_free) begin
        out_vld_d = 1'b1;
        out_d     = fin_res;
        state_d   = S_IDLE;
      end else begin
        res_d   = fin_res;
        state_d = S_HOLD;
      end
    end

    // A length write makes the table stale
    if (cfg.clr_built) begin
      built_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      built_q   <= 1'b0;
      lvl_q     <= '0;
      j_q       <= '0;
      wr_vld_q  <= 1'b0;
      wr_addr_q <= '0;
      res_q     <= '0;
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else begin
      state_q   <= state_d;
      built_q   <= built_d;
      lvl_q     <= lvl_d;
      j_q       <= j_d;
      wr_vld_q  <= wr_vld_d;
      wr_addr_q <= wr_addr_d;
      res_q     <= res_d;
      out_vld_q <= out_vld_d;
      out_q     <= out_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = srmq_pkg::OUT_DATA_W'({out_q.position, out_q.value});
  assign m_axis_tuser  = out_q.status;

endmodule

`default_nettype wire
